@@ hdl/rtc_date_to_epoch_seconds_assert.svh @@
`ifndef RTC_DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define RTC_DATE_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtce assertion failed");

`endif

@@ hdl/rtce_pkg.sv @@
package rtce_pkg;

  localparam logic [11:0] YearBase    = 12'd1900;
  localparam logic [11:0] YearWindow  = 12'd1970;
  localparam logic [11:0] YearCentury = 12'd100;
  localparam logic [11:0] Year2000    = 12'd2000;
  localparam logic [11:0] Year2100    = 12'd2100;
  localparam logic [31:0] DayBias     = 32'd719499;
  localparam logic [16:0] MonthMul    = 17'd367;
  localparam logic [16:0] Recip3      = 17'd43691;  // ceil(2^17 / 3)

  typedef struct packed {
    logic       vld;
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } rtce_fields_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] days;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } rtce_days_t;

  // low nibble plus ten times high nibble, or the byte as is
  function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bcd);
    logic [7:0] hi;
    hi = {4'b0000, b[7:4]};
    if (bcd) begin
      decode_byte = {4'b0000, b[3:0]} + (hi << 3) + (hi << 1);
    end else begin
      decode_byte = b;
    end
  endfunction

endpackage

@@ hdl/rtce_decode.sv @@
`include "rtc_date_to_epoch_seconds_assert.svh"

module rtce_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  bcd_i,
  input  rtce_pkg::rtce_fields_t raw_i,
  output rtce_pkg::rtce_fields_t dec_o
);
  import rtce_pkg::*;

  rtce_fields_t dec_d, dec_q;

  always_comb begin
    dec_d        = raw_i;
    dec_d.second = decode_byte(raw_i.second, bcd_i);
    dec_d.minute = decode_byte(raw_i.minute, bcd_i);
    dec_d.hour   = decode_byte(raw_i.hour, bcd_i);
    dec_d.day    = decode_byte(raw_i.day, bcd_i);
    dec_d.month  = decode_byte(raw_i.month, bcd_i);
    dec_d.year   = decode_byte(raw_i.year, bcd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= '0;
    end else begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

  // BCD decode can never exceed 165
  `RTCE_ASSERT_IMP(a_bcd_range, clk_i, rst_ni, dec_q.vld && $past(bcd_i),
    dec_q.year <= 8'd165 && dec_q.month <= 8'd165 && dec_q.day <= 8'd165 &&
    dec_q.hour <= 8'd165 && dec_q.minute <= 8'd165 && dec_q.second <= 8'd165)

endmodule

@@ hdl/rtce_days.sv @@
`include "rtc_date_to_epoch_seconds_assert.svh"

module rtce_days (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rtce_pkg::rtce_fields_t dec_i,
  output rtce_pkg::rtce_days_t   days_o
);
  import rtce_pkg::*;

  // stage A: year window and March-based month
  logic        a_vld_q;
  logic [11:0] a_year_d, a_year_q;
  logic [7:0]  a_mon_d, a_mon_q;
  logic [7:0]  a_day_q, a_hour_q, a_min_q, a_sec_q;
  logic [11:0] year_w;

  always_comb begin
    year_w = {4'b0000, dec_i.year} + YearBase;
    if (year_w < YearWindow) begin
      year_w = year_w + YearCentury;
    end
    if (dec_i.month <= 8'd2) begin
      a_mon_d  = dec_i.month + 8'd10;
      a_year_d = year_w - 12'd1;
    end else begin
      a_mon_d  = dec_i.month - 8'd2;
      a_year_d = year_w;
    end
  end

  // stage B: year day count and month product
  logic        b_vld_q;
  logic [20:0] b_yterm_d, b_yterm_q;
  logic [16:0] b_mprod_d, b_mprod_q;
  logic [7:0]  b_day_q, b_hour_q, b_min_q, b_sec_q;
  logic [4:0]  cent_w;
  logic [2:0]  quad_w;

  // year stays within 1969..2155, so centuries follow from two compares
  always_comb begin
    cent_w = (a_year_q >= Year2100) ? 5'd21 : ((a_year_q >= Year2000) ? 5'd20 : 5'd19);
    quad_w = (a_year_q >= Year2000) ? 3'd5 : 3'd4;
    b_yterm_d = 21'(a_year_q) * 21'd365 + 21'(a_year_q >> 2) + 21'(quad_w) - 21'(cent_w);
    b_mprod_d = 17'(a_mon_q) * MonthMul;
  end

  // stage C: month product over 12 by reciprocal, then the day sum
  logic [31:0] c_days_d;
  logic [31:0] recip_w;
  logic [14:0] mdiv_w;

  always_comb begin
    recip_w  = 32'(b_mprod_q[16:2]) * 32'(Recip3);
    mdiv_w   = recip_w[31:17];
    c_days_d = 32'(b_yterm_q) + 32'(mdiv_w) + 32'(b_day_q) - DayBias;
  end

  rtce_days_t days_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      days_q  <= '0;
    end else begin
      a_vld_q       <= dec_i.vld;
      b_vld_q       <= a_vld_q;
      days_q.vld    <= b_vld_q;
      days_q.days   <= c_days_d;
      days_q.hour   <= b_hour_q;
      days_q.minute <= b_min_q;
      days_q.second <= b_sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_year_q      <= a_year_d;
    a_mon_q       <= a_mon_d;
    a_day_q       <= dec_i.day;
    a_hour_q      <= dec_i.hour;
    a_min_q       <= dec_i.minute;
    a_sec_q       <= dec_i.second;
    b_yterm_q     <= b_yterm_d;
    b_mprod_q     <= b_mprod_d;
    b_day_q       <= a_day_q;
    b_hour_q      <= a_hour_q;
    b_min_q       <= a_min_q;
    b_sec_q       <= a_sec_q;
  end

  assign days_o = days_q;

  `RTCE_ASSERT_IMP(a_year_window, clk_i, rst_ni, a_vld_q,
    a_year_q >= 12'd1969 && a_year_q <= 12'd2155)
  `RTCE_ASSERT_IMP(a_month_div, clk_i, rst_ni, b_vld_q,
    18'(mdiv_w) * 18'd12 <= 18'(b_mprod_q) &&
    18'(b_mprod_q) < 18'(mdiv_w) * 18'd12 + 18'd12)

endmodule

@@ hdl/rtce_secs.sv @@
module rtce_secs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtce_pkg::rtce_days_t days_i,
  output logic                vld_o,
  output logic [31:0]         secs_o
);
  import rtce_pkg::*;

  logic        h_vld_q, m_vld_q, s_vld_q;
  logic [31:0] h_acc_d, h_acc_q;
  logic [31:0] m_acc_d, m_acc_q;
  logic [31:0] s_acc_d, s_acc_q;
  logic [7:0]  h_min_q, h_sec_q, m_sec_q;

  // one multiply-add per stage, all modulo 2^32
  always_comb begin
    h_acc_d = days_i.days * 32'd24 + 32'(days_i.hour);
    m_acc_d = h_acc_q * 32'd60 + 32'(h_min_q);
    s_acc_d = m_acc_q * 32'd60 + 32'(m_sec_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      h_vld_q <= days_i.vld;
      m_vld_q <= h_vld_q;
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_acc_q <= h_acc_d;
    h_min_q <= days_i.minute;
    h_sec_q <= days_i.second;
    m_acc_q <= m_acc_d;
    m_sec_q <= h_sec_q;
    s_acc_q <= s_acc_d;
  end

  assign vld_o  = s_vld_q;
  assign secs_o = s_acc_q;

endmodule

@@ hdl/rtc_date_to_epoch_seconds.sv @@
// Channel   Direction  Handshake                    Payload
// request   in         start / busy                 raw_second_i .. raw_year_i
// result    out        done_o (one-cycle strobe)    epoch_seconds_o
// config    in         cfg_valid_i / cfg_ready_o    cfg_data_i (fields_are_bcd)
//
// A new request may enter on every clock; busy stays low.
// Pipeline stages in order: decode, year/month fold, year and month terms,
// day sum, then hour, minute and second multiply-add stages.
// Reset clears every valid bit and sets fields_are_bcd to 1.
// Results are not held: done_o pulses for one cycle per request.
`include "rtc_date_to_epoch_seconds_assert.svh"

module rtc_date_to_epoch_seconds (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  raw_second_i,
  input  logic [7:0]  raw_minute_i,
  input  logic [7:0]  raw_hour_i,
  input  logic [7:0]  raw_day_i,
  input  logic [7:0]  raw_month_i,
  input  logic [7:0]  raw_year_i,
  output logic        done_o,
  output logic [31:0] epoch_seconds_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import rtce_pkg::*;

  // the pipeline never stalls, so requests and writes are always taken
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic bcd_q;

  // hold the encoding flag; a request taken on the write edge uses the old value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bcd_q <= cfg_data_i;
    end
  end

  rtce_fields_t raw_w, dec_w;
  rtce_days_t   days_w;

  // pack the snapshot; valid marks an accepted request
  always_comb begin
    raw_w.vld    = start && !busy;
    raw_w.second = raw_second_i;
    raw_w.minute = raw_minute_i;
    raw_w.hour   = raw_hour_i;
    raw_w.day    = raw_day_i;
    raw_w.month  = raw_month_i;
    raw_w.year   = raw_year_i;
  end

  // decode BCD or pass binary bytes through
  rtce_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bcd_i  (bcd_q),
    .raw_i  (raw_w),
    .dec_o  (dec_w)
  );

  // window the year, fold the month and count days
  rtce_days u_days (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dec_i  (dec_w),
    .days_o (days_w)
  );

  // advance days into hours, minutes and seconds
  rtce_secs u_secs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .days_i (days_w),
    .vld_o  (done_o),
    .secs_o (epoch_seconds_o)
  );

  `RTCE_ASSERT_NEXT(a_accept_to_decode, clk_i, rst_ni, start && !busy, dec_w.vld)
  `RTCE_ASSERT_IMP(a_done_has_request, clk_i, rst_ni, done_o, $past(start && !busy, 7))

endmodule
